// ===== sv/acctilt_pkg.sv =====
// shared types, constants and the arctangent table of the tilt angle unit
`timescale 1ns / 1ps
`default_nettype none

package acctilt_pkg;

    // default configuration
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // sum of squares is scaled by 2^16 before the root, so the root gains 8 fraction bits
    localparam int SQRT_PRESCALE = 16;
    // headroom above the sample width for the rotation datapath
    localparam int CORDIC_GUARD  = 11;

    // angle accumulator, radians Q30
    localparam int ANG_W           = 32;
    localparam int ATAN_TABLE_SIZE = 24;
    localparam logic signed [ANG_W-1:0] QUARTER_Q30 = 32'sd1686629713;

    // unit conversion
    localparam int ANGLE_W   = 16;
    localparam int MAG_W     = ANG_W - 1;
    localparam int DEG_K_W   = 24;
    localparam logic [DEG_K_W-1:0] DEG_K = 24'd15019745;
    localparam int DEG_SHIFT = 40;
    localparam int RAD_SHIFT = 17;
    localparam logic [ANGLE_W-1:0] RAD_LIMIT = 16'd12868;
    localparam logic [ANGLE_W-1:0] DEG_LIMIT = 16'd23040;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd23040;

    // angle unit selected by the mode register
    typedef enum logic {
        UNIT_RAD = 1'b0,
        UNIT_DEG = 1'b1
    } t_unit;

    // per-item control that travels alongside the data
    typedef struct packed {
        logic valid;
        logic nonzero;
        logic vertical;
        logic x_neg;
    } t_ctl;

    // atan(2^-i) in radians Q30, truncated
    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            0:       v = 32'sh3243F6A8;
            1:       v = 32'sh1DAC6705;
            2:       v = 32'sh0FADBAFC;
            3:       v = 32'sh07F56EA6;
            4:       v = 32'sh03FEAB76;
            5:       v = 32'sh01FFD55B;
            6:       v = 32'sh00FFFAAA;
            7:       v = 32'sh007FFF55;
            8:       v = 32'sh003FFFEA;
            9:       v = 32'sh001FFFFD;
            10:      v = 32'sh000FFFFF;
            11:      v = 32'sh0007FFFF;
            12:      v = 32'sh0003FFFF;
            13:      v = 32'sh0001FFFF;
            14:      v = 32'sh0000FFFF;
            15:      v = 32'sh00007FFF;
            16:      v = 32'sh00003FFF;
            17:      v = 32'sh00001FFF;
            18:      v = 32'sh00000FFF;
            19:      v = 32'sh000007FF;
            20:      v = 32'sh000003FF;
            21:      v = 32'sh000001FF;
            22:      v = 32'sh000000FF;
            23:      v = 32'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/acctilt_in_if.sv =====
// sample channel: valid, ready and the three axis counts
`timescale 1ns / 1ps
`default_nettype none

interface acctilt_in_if
    import acctilt_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;
    logic signed [W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

`default_nettype wire

// ===== sv/acctilt_out_if.sv =====
// result channel: valid, ready, angle and defined flag
`timescale 1ns / 1ps
`default_nettype none

interface acctilt_out_if
    import acctilt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic                      angle_defined;

    modport source (output valid, output tilt_angle, output angle_defined, input ready);
    modport sink   (input valid, input tilt_angle, input angle_defined, output ready);
endinterface

`default_nettype wire

// ===== sv/accel_tilt_angle_unit.sv =====
// top level of the accelerometer tilt angle unit
//
//  channel    dir  flow         payload
//  i_sample   in   valid/ready  accel_x, accel_y, accel_z (SAMPLE_WIDTH, signed)
//  o_result   out  valid/ready  tilt_angle (16, signed), angle_defined (1)
//  unit_mode  in   write enable i_unit_mode_wdata (1)
//
//  one item enters every cycle while the chain is not held. an item passes squares and sum,
//  one root bit per square root cell, one rotation per CORDIC cell, then clamp,
//  degree product and output register.
//  reset is synchronous and clears only the valid bits and the mode register.
//  the whole chain holds while the output register keeps an item not yet taken.
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_angle_unit
    import acctilt_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_unit_mode_we,
    input  wire logic     i_unit_mode_wdata,
    acctilt_in_if.sink    i_sample,
    acctilt_out_if.source o_result
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int SW = 2 * W;
    localparam int RW = W + SQRT_PRESCALE / 2;
    localparam int CW = W + CORDIC_GUARD;
    localparam int XS = SQRT_PRESCALE / 2;

    logic                 w_en;
    logic                 w_out_valid;
    t_ctl                 w_in_ctl;
    logic signed [SW-1:0] w_yy;
    logic signed [SW-1:0] w_zz;

    t_unit                r_unit_mode;
    t_ctl                 r_s0_ctl;
    logic [SW-1:0]        r_yy;
    logic [SW-1:0]        r_zz;
    logic signed [W-1:0]  r_s0_x;
    t_ctl                 r_s1_ctl;
    logic [SW-1:0]        r_s;
    logic signed [W-1:0]  r_s1_x;

    t_ctl                 sq_ctl  [RW+1];
    logic [SW-1:0]        sq_s    [RW];
    logic signed [W-1:0]  sq_x    [RW+1];
    logic [RW+1:0]        sq_rem  [RW+1];
    logic [RW-1:0]        sq_root [RW+1];

    t_ctl                    cr_ctl [CORDIC_STAGES+1];
    logic signed [CW-1:0]    cr_a   [CORDIC_STAGES];
    logic signed [CW-1:0]    cr_b   [CORDIC_STAGES];
    logic signed [ANG_W-1:0] cr_ang [CORDIC_STAGES+1];

    // the chain moves whenever the output register is free or being emptied
    assign w_en           = !w_out_valid || o_result.ready;
    assign i_sample.ready = w_en;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_mode <= UNIT_RAD;
        end else if (i_unit_mode_we) begin
            r_unit_mode <= t_unit'(i_unit_mode_wdata);
        end
    end

    // sample classification and squares
    always_comb begin
        w_in_ctl.valid    = i_sample.valid;
        w_in_ctl.nonzero  = (i_sample.accel_x != '0) || (i_sample.accel_y != '0) ||
                            (i_sample.accel_z != '0);
        w_in_ctl.vertical = (i_sample.accel_y == '0) && (i_sample.accel_z == '0);
        w_in_ctl.x_neg    = i_sample.accel_x[W-1];
    end

    assign w_yy = SW'(i_sample.accel_y) * SW'(i_sample.accel_y);
    assign w_zz = SW'(i_sample.accel_z) * SW'(i_sample.accel_z);

    // front stages control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.valid <= 1'b0;
            r_s1_ctl.valid <= 1'b0;
        end else if (w_en) begin
            r_s0_ctl <= w_in_ctl;
            r_s1_ctl <= r_s0_ctl;
        end
    end

    // front stages data: squares, then their sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yy   <= w_yy;
            r_zz   <= w_zz;
            r_s0_x <= i_sample.accel_x;
            r_s    <= r_yy + r_zz;
            r_s1_x <= r_s0_x;
        end
    end

    // square root chain, most significant root bit first
    assign sq_ctl[0]  = r_s1_ctl;
    assign sq_s[0]    = r_s;
    assign sq_x[0]    = r_s1_x;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        if (g == RW - 1) begin : g_last
            acctilt_sqrt_cell #(
                .W (W),
                .K (RW - 1 - g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_ctl  (sq_ctl[g]),
                .i_s    (sq_s[g]),
                .i_x    (sq_x[g]),
                .i_rem  (sq_rem[g]),
                .i_root (sq_root[g]),
                .o_ctl  (sq_ctl[g+1]),
                .o_s    (),
                .o_x    (sq_x[g+1]),
                .o_rem  (sq_rem[g+1]),
                .o_root (sq_root[g+1])
            );
        end else begin : g_mid
            acctilt_sqrt_cell #(
                .W (W),
                .K (RW - 1 - g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_ctl  (sq_ctl[g]),
                .i_s    (sq_s[g]),
                .i_x    (sq_x[g]),
                .i_rem  (sq_rem[g]),
                .i_root (sq_root[g]),
                .o_ctl  (sq_ctl[g+1]),
                .o_s    (sq_s[g+1]),
                .o_x    (sq_x[g+1]),
                .o_rem  (sq_rem[g+1]),
                .o_root (sq_root[g+1])
            );
        end
    end

    // rotation chain starts from (root, x * 2^8) at zero angle
    assign cr_ctl[0] = sq_ctl[RW];
    assign cr_a[0]   = $signed({{(CW - RW){1'b0}}, sq_root[RW]});
    assign cr_b[0]   = $signed({{(CW - W - XS){sq_x[RW][W-1]}}, sq_x[RW], {XS{1'b0}}});
    assign cr_ang[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        if (g == CORDIC_STAGES - 1) begin : g_last
            acctilt_cordic_cell #(
                .CW(CW),
                .I (g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_ctl  (cr_ctl[g]),
                .i_a    (cr_a[g]),
                .i_b    (cr_b[g]),
                .i_ang  (cr_ang[g]),
                .o_ctl  (cr_ctl[g+1]),
                .o_a    (),
                .o_b    (),
                .o_ang  (cr_ang[g+1])
            );
        end else begin : g_mid
            acctilt_cordic_cell #(
                .CW(CW),
                .I (g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_ctl  (cr_ctl[g]),
                .i_a    (cr_a[g]),
                .i_b    (cr_b[g]),
                .i_ang  (cr_ang[g]),
                .o_ctl  (cr_ctl[g+1]),
                .o_a    (cr_a[g+1]),
                .o_b    (cr_b[g+1]),
                .o_ang  (cr_ang[g+1])
            );
        end
    end

    // unit conversion and output register
    acctilt_convert u_convert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_unit   (r_unit_mode),
        .i_ctl    (cr_ctl[CORDIC_STAGES]),
        .i_ang    (cr_ang[CORDIC_STAGES]),
        .o_valid  (w_out_valid),
        .o_angle  (o_result.tilt_angle),
        .o_defined(o_result.angle_defined)
    );

    assign o_result.valid = w_out_valid;

    // reset empties the output register
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");

    // an all-zero sample gives a zero angle
    a_undefined_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.angle_defined |-> o_result.tilt_angle == '0)
        else $error("undefined angle not zero");

    // angle never leaves a quarter turn in degrees
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.tilt_angle <= ANGLE_MAX) &&
                           (o_result.tilt_angle >= -ANGLE_MAX))
        else $error("angle out of range");
endmodule

`default_nettype wire

// ===== sv/acctilt_sqrt_cell.sv =====
// one cell of the square root chain: settles one root bit per cycle while enabled
`timescale 1ns / 1ps
`default_nettype none

module acctilt_sqrt_cell
    import acctilt_pkg::*;
#(
    parameter int W = SAMPLE_WIDTH_DEF,
    parameter int K = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_ctl                    i_ctl,
    input  wire logic [2*W-1:0]          i_s,
    input  wire logic signed [W-1:0]     i_x,
    input  wire logic [W+SQRT_PRESCALE/2+1:0] i_rem,
    input  wire logic [W+SQRT_PRESCALE/2-1:0] i_root,
    output t_ctl                         o_ctl,
    output logic [2*W-1:0]               o_s,
    output logic signed [W-1:0]          o_x,
    output logic [W+SQRT_PRESCALE/2+1:0] o_rem,
    output logic [W+SQRT_PRESCALE/2-1:0] o_root
);
    localparam int RW = W + SQRT_PRESCALE / 2;

    logic [2*RW-1:0] w_n;
    logic [RW+3:0]   w_cur;
    logic [RW+3:0]   w_trial;
    logic [RW+3:0]   w_diff;
    logic            w_ge;

    t_ctl                r_ctl;
    logic [2*W-1:0]      r_s;
    logic signed [W-1:0] r_x;
    logic [RW+1:0]       r_rem;
    logic [RW-1:0]       r_root;
    logic [RW+1:0]       n_rem;
    logic [RW-1:0]       n_root;

    // bring down the next pair of radicand bits and try the next root bit
    assign w_n     = {i_s, {SQRT_PRESCALE{1'b0}}};
    assign w_cur   = {i_rem, w_n[2*K+1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_ge    = (w_cur >= w_trial);
    assign n_rem   = w_ge ? w_diff[RW+1:0] : w_cur[RW+1:0];
    assign n_root  = {i_root[RW-2:0], w_ge};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= i_s;
            r_x    <= i_x;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_s    = r_s;
    assign o_x    = r_x;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

`default_nettype wire

// ===== sv/acctilt_cordic_cell.sv =====
// one vectoring rotation cell: drives the second coordinate towards zero
`timescale 1ns / 1ps
`default_nettype none

module acctilt_cordic_cell
    import acctilt_pkg::*;
#(
    parameter int CW = SAMPLE_WIDTH_DEF + CORDIC_GUARD,
    parameter int I  = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_ctl                    i_ctl,
    input  wire logic signed [CW-1:0]    i_a,
    input  wire logic signed [CW-1:0]    i_b,
    input  wire logic signed [ANG_W-1:0] i_ang,
    output t_ctl                         o_ctl,
    output logic signed [CW-1:0]         o_a,
    output logic signed [CW-1:0]         o_b,
    output logic signed [ANG_W-1:0]      o_ang
);
    localparam logic signed [ANG_W-1:0] STEP = atan_q30(I);

    logic signed [CW-1:0] w_da;
    logic signed [CW-1:0] w_db;

    t_ctl                    r_ctl;
    logic signed [CW-1:0]    r_a;
    logic signed [CW-1:0]    r_b;
    logic signed [ANG_W-1:0] r_ang;
    logic signed [CW-1:0]    n_a;
    logic signed [CW-1:0]    n_b;
    logic signed [ANG_W-1:0] n_ang;

    // shifted cross terms, floor rounding
    assign w_da = i_b >>> I;
    assign w_db = i_a >>> I;

    // rotate against the sign of the second coordinate
    always_comb begin
        if (!i_b[CW-1]) begin
            n_a   = i_a + w_da;
            n_b   = i_b - w_db;
            n_ang = i_ang + STEP;
        end else begin
            n_a   = i_a - w_da;
            n_b   = i_b + w_db;
            n_ang = i_ang - STEP;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_ang <= n_ang;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_ang = r_ang;
endmodule

`default_nettype wire

// ===== sv/acctilt_convert.sv =====
// angle clamp, unit conversion, rounding and the output register
`timescale 1ns / 1ps
`default_nettype none

module acctilt_convert
    import acctilt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_unit                   i_unit,
    input  wire t_ctl                    i_ctl,
    input  wire logic signed [ANG_W-1:0] i_ang,
    output logic                         o_valid,
    output logic signed [ANGLE_W-1:0]    o_angle,
    output logic                         o_defined
);
    localparam int PROD_W = MAG_W + DEG_K_W;

    logic signed [ANG_W-1:0] w_clamp;
    logic signed [ANG_W-1:0] w_sel;
    logic signed [ANG_W-1:0] w_abs;
    logic [PROD_W:0]         w_deg_sum;
    logic [MAG_W:0]          w_rad_sum;
    logic [ANGLE_W-1:0]      w_deg;
    logic [ANGLE_W-1:0]      w_rad;
    logic [ANGLE_W-1:0]      w_mag;

    t_ctl                     r_a_ctl;
    logic [MAG_W-1:0]         r_a_m;
    logic                     r_a_neg;
    t_ctl                     r_b_ctl;
    logic [PROD_W-1:0]        r_b_prod;
    logic [MAG_W-1:0]         r_b_m;
    logic                     r_b_neg;
    logic                     r_c_valid;
    logic signed [ANGLE_W-1:0] r_c_angle;
    logic                     r_c_defined;
    logic signed [ANGLE_W-1:0] n_c_angle;

    // clamp to a quarter turn, vertical sample takes the quarter turn outright
    always_comb begin
        if (i_ang > QUARTER_Q30) begin
            w_clamp = QUARTER_Q30;
        end else if (i_ang < -QUARTER_Q30) begin
            w_clamp = -QUARTER_Q30;
        end else begin
            w_clamp = i_ang;
        end
        if (i_ctl.vertical) begin
            w_sel = i_ctl.x_neg ? -QUARTER_Q30 : QUARTER_Q30;
        end else begin
            w_sel = w_clamp;
        end
        w_abs = w_sel[ANG_W-1] ? -w_sel : w_sel;
    end

    // rounding and limits on the magnitude, sign restored afterwards
    assign w_deg_sum = {1'b0, r_b_prod} + ((PROD_W + 1)'(1) << (DEG_SHIFT - 1));
    assign w_rad_sum = {1'b0, r_b_m} + ((MAG_W + 1)'(1) << (RAD_SHIFT - 1));
    assign w_deg     = w_deg_sum[DEG_SHIFT +: ANGLE_W];
    assign w_rad     = ANGLE_W'(w_rad_sum[MAG_W:RAD_SHIFT]);

    always_comb begin
        unique case (i_unit)
            UNIT_DEG: w_mag = (w_deg > DEG_LIMIT) ? DEG_LIMIT : w_deg;
            UNIT_RAD: w_mag = (w_rad > RAD_LIMIT) ? RAD_LIMIT : w_rad;
            default:  w_mag = '0;
        endcase
        if (!r_b_ctl.nonzero) begin
            n_c_angle = '0;
        end else if (r_b_neg) begin
            n_c_angle = -$signed(w_mag);
        end else begin
            n_c_angle = $signed(w_mag);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_b_ctl.valid <= 1'b0;
            r_c_valid     <= 1'b0;
        end else if (i_en) begin
            r_a_ctl   <= i_ctl;
            r_b_ctl   <= r_a_ctl;
            r_c_valid <= r_b_ctl.valid;
        end
    end

    // data: magnitude, degree product, final result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_m       <= w_abs[MAG_W-1:0];
            r_a_neg     <= w_sel[ANG_W-1];
            r_b_prod    <= PROD_W'(r_a_m) * PROD_W'(DEG_K);
            r_b_m       <= r_a_m;
            r_b_neg     <= r_a_neg;
            r_c_angle   <= n_c_angle;
            r_c_defined <= r_b_ctl.nonzero;
        end
    end

    assign o_valid   = r_c_valid;
    assign o_angle   = r_c_angle;
    assign o_defined = r_c_defined;
endmodule

`default_nettype wire

// ===== verif/accel_tilt_angle_unit_tb.sv =====
// self-checking testbench for the accelerometer tilt angle unit
`timescale 1ns / 1ps

module accel_tilt_angle_unit_tb;
    import acctilt_pkg::*;

    localparam int     SMP_W          = 16;
    localparam int     STAGES         = 16;
    localparam int     PIPE_LATENCY   = 45;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam longint QUARTER_Q30_TB = 64'sd1686629713;
    localparam longint DEG_SCALE      = 64'sd15019745;
    localparam longint RAD_CLAMP      = 64'sd12868;
    localparam longint DEG_CLAMP      = 64'sd23040;

    // one expected result
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      defined;
    } t_tilt;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_unit_mode_we;
    logic i_unit_mode_wdata;

    acctilt_in_if #(.W(SMP_W)) smp_ch ();
    acctilt_out_if             res_ch ();

    accel_tilt_angle_unit #(
        .SAMPLE_WIDTH  (SMP_W),
        .CORDIC_STAGES (STAGES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_unit_mode_we    (i_unit_mode_we),
        .i_unit_mode_wdata (i_unit_mode_wdata),
        .i_sample          (smp_ch),
        .o_result          (res_ch)
    );

    // atan(2^-i), radians Q30, truncated
    longint atan_steps [STAGES] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
        64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
        64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
        64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF
    };

    t_tilt tilt_expected[$];
    t_unit unit_sel;
    int    error_count;
    int    idle_cycles;
    bit    src_gaps_on;
    bit    snk_stalls_on;

    always #4 i_clk = ~i_clk;

    // integer square root, one result bit per pass
    function automatic longint int_sqrt(longint n);
        longint root;
        longint place;
        root  = 0;
        place = 64'sd1 <<< 62;
        while (place > n)
            place = place >>> 2;
        while (place != 0) begin
            if (n >= root + place) begin
                n    = n - (root + place);
                root = (root >>> 1) + place;
            end else begin
                root = root >>> 1;
            end
            place = place >>> 2;
        end
        return root;
    endfunction

    // expected angle and defined flag of one sample
    function automatic t_tilt predict_tilt(logic signed [SMP_W-1:0] ax,
                                           logic signed [SMP_W-1:0] ay,
                                           logic signed [SMP_W-1:0] az);
        longint x, y, z;
        longint a, b, da, db, ang, mag, conv;
        bit     neg;
        int     i;
        t_tilt  r;
        x = 64'(ax);
        y = 64'(ay);
        z = 64'(az);
        r.defined = 1'b1;
        ang = 0;
        if (x == 0 && y == 0 && z == 0) begin
            r.angle   = '0;
            r.defined = 1'b0;
            return r;
        end
        if (y == 0 && z == 0) begin
            ang = (x > 0) ? QUARTER_Q30_TB : -QUARTER_Q30_TB;
        end else begin
            // vectoring rotation from (root of y^2+z^2, x), both with 8 fraction bits
            a = int_sqrt((y * y + z * z) <<< 16);
            b = x * 256;
            for (i = 0; i < STAGES; i++) begin
                da = b >>> i;
                db = a >>> i;
                if (b >= 0) begin
                    a   = a + da;
                    b   = b - db;
                    ang = ang + atan_steps[i];
                end else begin
                    a   = a - da;
                    b   = b + db;
                    ang = ang - atan_steps[i];
                end
            end
            if (ang > QUARTER_Q30_TB)
                ang = QUARTER_Q30_TB;
            if (ang < -QUARTER_Q30_TB)
                ang = -QUARTER_Q30_TB;
        end
        // unit conversion on the magnitude, sign put back afterwards
        neg = (ang < 0);
        mag = neg ? -ang : ang;
        if (unit_sel == UNIT_DEG) begin
            conv = (mag * DEG_SCALE + (64'sd1 <<< 39)) >>> 40;
            if (conv > DEG_CLAMP)
                conv = DEG_CLAMP;
        end else begin
            conv = (mag + 64'sd65536) >>> 17;
            if (conv > RAD_CLAMP)
                conv = RAD_CLAMP;
        end
        r.angle = neg ? ANGLE_W'(-conv) : ANGLE_W'(conv);
        return r;
    endfunction

    // send one item, with a random gap in front of it while source gaps are on
    task automatic send_sample(logic signed [SMP_W-1:0] x,
                               logic signed [SMP_W-1:0] y,
                               logic signed [SMP_W-1:0] z);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid   <= 1'b1;
        smp_ch.accel_x <= x;
        smp_ch.accel_y <= y;
        smp_ch.accel_z <= z;
        do @(posedge i_clk); while (!smp_ch.ready);
        tilt_expected.push_back(predict_tilt(x, y, z));
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results();
        smp_ch.valid <= 1'b0;
        while (tilt_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // write the unit register while the pipeline is empty
    task automatic set_unit(t_unit mode);
        drain_results();
        @(posedge i_clk);
        i_unit_mode_we    <= 1'b1;
        i_unit_mode_wdata <= mode;
        @(posedge i_clk);
        i_unit_mode_we    <= 1'b0;
        unit_sel = mode;
    endtask

    // full-scale and near-zero axis combinations
    task automatic test_axis_extremes();
        send_sample(16'sh7FFF, 16'sh0000, 16'sh0000);
        send_sample(16'sh8000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh7FFF, 16'sh0000);
        send_sample(16'sh0000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh0001, 16'sh8000, 16'sh0000);
        send_sample(16'shFFFF, 16'sh0000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh0001, 16'sh0000);
        send_sample(16'sh8000, 16'sh0000, 16'shFFFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    endtask

    // all-zero sample, vertical samples and the 45 degree cases
    task automatic test_degenerate_samples();
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0005, 16'sh0000, 16'sh0000);
        send_sample(-16'sh0005, 16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'sh0000, 16'sh0000);
        send_sample(16'shFFFF, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0064, 16'sh0064, 16'sh0000);
        send_sample(-16'sh0064, 16'sh0000, -16'sh0064);
    endtask

    // random samples of mixed shape, idling switched on and off in stretches
    task automatic test_random_samples(int n);
        logic signed [SMP_W-1:0] x, y, z;
        int k;
        int kind;
        for (k = 0; k < n; k++) begin
            if (k % 64 == 0) begin
                src_gaps_on   = ($urandom_range(0, 3) != 0);
                snk_stalls_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            x = SMP_W'($urandom());
            y = SMP_W'($urandom());
            z = SMP_W'($urandom());
            case (kind)
                4: begin
                    x = SMP_W'($urandom_range(0, 32) - 16);
                    y = SMP_W'($urandom_range(0, 32) - 16);
                    z = SMP_W'($urandom_range(0, 32) - 16);
                end
                5: begin
                    // vertical, sometimes all zero
                    if ($urandom_range(0, 3) == 0)
                        x = '0;
                    y = '0;
                    z = '0;
                end
                6: begin
                    x = '0;
                end
                7: begin
                    // x dominates
                    y = SMP_W'($urandom_range(0, 64) - 32);
                    z = SMP_W'($urandom_range(0, 64) - 32);
                end
                8: begin
                    x = SMP_W'($urandom_range(0, 64) - 32);
                end
                9: begin
                    if ($urandom_range(0, 1)) x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    if ($urandom_range(0, 1)) y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    if ($urandom_range(0, 1)) z = $urandom_range(0, 1) ? 16'sh7FFE : 16'sh8001;
                end
                default: ;
            endcase
            send_sample(x, y, z);
        end
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
    endtask

    // result side: random stall before each item while sink stalls are on
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = snk_stalls_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_tilt want;
        if (i_rst_n) begin
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_ch.valid && res_ch.ready) begin
                if (tilt_expected.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: angle %0d defined %0b",
                                 res_ch.tilt_angle, res_ch.angle_defined);
                end else begin
                    want = tilt_expected.pop_front();
                    if (res_ch.tilt_angle !== want.angle) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("tilt_angle mismatch: expected %0d actual %0d",
                                     want.angle, res_ch.tilt_angle);
                    end
                    if (res_ch.angle_defined !== want.defined) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("angle_defined mismatch: expected %0b actual %0b",
                                     want.defined, res_ch.angle_defined);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n           <= 1'b0;
        i_unit_mode_we    <= 1'b0;
        i_unit_mode_wdata <= 1'b0;
        smp_ch.valid      <= 1'b0;
        smp_ch.accel_x    <= '0;
        smp_ch.accel_y    <= '0;
        smp_ch.accel_z    <= '0;
        unit_sel      = UNIT_RAD;
        error_count   = 0;
        idle_cycles   = 0;
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_unit(UNIT_RAD);
        test_axis_extremes();
        set_unit(UNIT_DEG);
        test_degenerate_samples();
        test_random_samples(350);
        set_unit(UNIT_RAD);
        test_random_samples(300);
        set_unit(UNIT_DEG);
        test_random_samples(50);

        drain_results();
        repeat (PIPE_LATENCY + 15) @(posedge i_clk);
        if (error_count == 0 && tilt_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
